// ===== src/jsfe_pkg.sv =====
// Shared types, constants and decode helpers for the JSON string field extractor.
package jsfe_pkg;

   localparam int KEY_MAX_DEF = 8;
   localparam int RSP_DEPTH   = 4;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int KEY_BYTES_W = 64;
   localparam int KEY_LEN_W   = 4;

   localparam logic [7:0]  CH_QUOTE     = 8'h22;
   localparam logic [7:0]  CH_COLON     = 8'h3A;
   localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
   localparam logic [7:0]  CH_U         = 8'h75;
   localparam logic [7:0]  CTRL_LIMIT   = 8'h20;
   localparam logic [15:0] HEX_MAX      = 16'h007F;
   localparam logic [2:0]  HEX_DIGITS   = 3'd4;

   typedef enum logic {
      REG_KEY_BYTES  = 1'b0,
      REG_KEY_LENGTH = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_VALUE  = 3'd1,
      PH_ESC    = 3'd2,
      PH_HEX    = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_BYTE      = 2'd0,
      ST_COMPLETE  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_MALFORMED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      status_type status;
      logic       field_done;
   } rsp_type;

   // Up to two result beats per input beat, oldest in first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic [KEY_BYTES_W-1:0] key_bytes;
      logic [KEY_LEN_W-1:0]   key_length;
   } cfg_type;

   // {ok, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // {ok, decoded byte} for a single-character escape
   function automatic logic [8:0] escape_value(input logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h22:   r = {1'b1, 8'h22};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/jsfe_csr.sv =====
// Configuration registers and their APB-style access port.
module jsfe_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [jsfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [jsfe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [jsfe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output jsfe_pkg::cfg_type                cfg
);
   import jsfe_pkg::*;

   logic [KEY_BYTES_W-1:0] key_bytes_ff;
   logic [KEY_LEN_W-1:0]   key_length_ff;
   logic                   wr_en;
   reg_index_type          idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // 64-bit registers sit on 8-byte strides
   assign idx        = reg_index_type'(csr_paddr[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff  <= '0;
         key_length_ff <= KEY_LEN_W'(1);
      end else if (wr_en) begin
         unique case (idx)
            REG_KEY_BYTES:  key_bytes_ff  <= csr_pwdata;
            REG_KEY_LENGTH: key_length_ff <= csr_pwdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KEY_BYTES:  csr_prdata = key_bytes_ff;
         REG_KEY_LENGTH: csr_prdata = CSR_DATA_W'(key_length_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.key_bytes  = key_bytes_ff;
   assign cfg.key_length = key_length_ff;

endmodule

// ===== src/jsfe_step.sv =====
// Per-byte decode: marker window, value phase machine and escape decoding.
module jsfe_step #(
   parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               end_of_text,
   input  jsfe_pkg::cfg_type  cfg,
   output jsfe_pkg::push_type push
);
   import jsfe_pkg::*;

   localparam int WinDepth = KEY_MAX + 4;
   localparam int WinIdxW  = $clog2(WinDepth);

   logic [7:0]   win_ff [WinDepth];
   logic [7:0]   win_shift [WinDepth];
   phase_type    phase_ff, phase_in, phase_mid;
   logic [2:0]   digits_ff, digits_in;
   logic [15:0]  acc_ff, acc_in;

   logic [KEY_LEN_W-1:0] klen;
   logic         marker;
   logic [4:0]   hv;
   logic [8:0]   ev;
   logic [15:0]  acc_next;
   logic [2:0]   digits_next;
   logic         p_valid, e_valid;
   rsp_type      p_rsp, e_rsp;

   // Clamp key length into 1..KEY_MAX
   always_comb begin
      priority if (cfg.key_length == '0) begin
         klen = KEY_LEN_W'(1);
      end else if (cfg.key_length > KEY_LEN_W'(KEY_MAX)) begin
         klen = KEY_LEN_W'(KEY_MAX);
      end else begin
         klen = cfg.key_length;
      end
   end

   always_comb begin
      win_shift[0] = in_byte;
      for (int i = 1; i < WinDepth; i++) begin
         win_shift[i] = win_ff[i-1];
      end
   end

   // Newest byte first: quote colon quote, key reversed, opening quote
   always_comb begin
      logic [2:0] kpos;
      marker = (win_shift[0] == CH_QUOTE) && (win_shift[1] == CH_COLON) &&
               (win_shift[2] == CH_QUOTE) &&
               (win_shift[WinIdxW'(klen) + WinIdxW'(3)] == CH_QUOTE);
      for (int i = 0; i < KEY_MAX; i++) begin
         kpos = 3'(klen - KEY_LEN_W'(1) - KEY_LEN_W'(i));
         if (KEY_LEN_W'(i) < klen) begin
            if (win_shift[3+i] != cfg.key_bytes[8*kpos +: 8]) begin
               marker = 1'b0;
            end
         end
      end
   end

   assign hv          = hex_value(in_byte);
   assign ev          = escape_value(in_byte);
   assign acc_next    = {acc_ff[11:0], hv[3:0]};
   assign digits_next = digits_ff + 3'd1;

   always_comb begin
      phase_mid = phase_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      p_valid   = 1'b0;
      p_rsp     = '{out_byte: 8'd0, byte_valid: 1'b0, status: ST_MALFORMED,
                    field_done: 1'b1};
      unique case (phase_ff)
         PH_SEARCH: begin
            if (marker) begin
               phase_mid = PH_VALUE;
            end
         end
         PH_VALUE: begin
            priority if (in_byte == CH_BACKSLASH) begin
               phase_mid = PH_ESC;
            end else if (in_byte == CH_QUOTE) begin
               p_valid      = 1'b1;
               p_rsp.status = ST_COMPLETE;
               phase_mid    = PH_DONE;
            end else if (in_byte < CTRL_LIMIT) begin
               p_valid   = 1'b1;
               phase_mid = PH_DONE;
            end else begin
               p_valid = 1'b1;
               p_rsp   = '{out_byte: in_byte, byte_valid: 1'b1, status: ST_BYTE,
                           field_done: 1'b0};
            end
         end
         PH_ESC: begin
            priority if (in_byte == CH_U) begin
               phase_mid = PH_HEX;
               digits_in = 3'd0;
               acc_in    = 16'd0;
            end else if (ev[8]) begin
               p_valid   = 1'b1;
               p_rsp     = '{out_byte: ev[7:0], byte_valid: 1'b1, status: ST_BYTE,
                             field_done: 1'b0};
               phase_mid = PH_VALUE;
            end else begin
               p_valid   = 1'b1;
               phase_mid = PH_DONE;
            end
         end
         PH_HEX: begin
            priority if (!hv[4]) begin
               p_valid   = 1'b1;
               phase_mid = PH_DONE;
            end else if (digits_next >= HEX_DIGITS) begin
               p_valid   = 1'b1;
               digits_in = 3'd0;
               acc_in    = 16'd0;
               if (acc_next > HEX_MAX) begin
                  phase_mid = PH_DONE;
               end else begin
                  p_rsp     = '{out_byte: acc_next[7:0], byte_valid: 1'b1,
                                status: ST_BYTE, field_done: 1'b0};
                  phase_mid = PH_VALUE;
               end
            end else begin
               digits_in = digits_next;
               acc_in    = acc_next;
            end
         end
         default: phase_mid = PH_DONE;
      endcase
   end

   // End of text closes any open field
   always_comb begin
      e_valid = end_of_text && (phase_mid != PH_DONE);
      e_rsp   = '{out_byte: 8'd0, byte_valid: 1'b0,
                  status: (phase_mid == PH_SEARCH) ? ST_NOT_FOUND : ST_MALFORMED,
                  field_done: 1'b1};
      phase_in = end_of_text ? PH_SEARCH : phase_mid;
   end

   always_comb begin
      push.count  = accept ? (2'(p_valid) + 2'(e_valid)) : 2'd0;
      push.first  = p_valid ? p_rsp : e_rsp;
      push.second = e_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         digits_ff <= 3'd0;
         acc_ff    <= 16'd0;
         for (int i = 0; i < WinDepth; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else if (accept) begin
         phase_ff <= phase_in;
         if (end_of_text) begin
            digits_ff <= 3'd0;
            acc_ff    <= 16'd0;
            for (int i = 0; i < WinDepth; i++) begin
               win_ff[i] <= 8'd0;
            end
         end else begin
            digits_ff <= digits_in;
            acc_ff    <= acc_in;
            if (phase_ff == PH_SEARCH) begin
               for (int i = 0; i < WinDepth; i++) begin
                  win_ff[i] <= win_shift[i];
               end
            end
         end
      end
   end

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DONE && !end_of_text) |-> push.count == 2'd0)
      else $error("finished field produced a result");

   a_text_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_text) |=> (phase_ff == PH_SEARCH && digits_ff == 3'd0))
      else $error("state not cleared after final beat");

   a_two_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (end_of_text && push.second.field_done))
      else $error("second result without end of text");

   a_hex_count: assert property (@(posedge clock) disable iff (reset)
      digits_ff < HEX_DIGITS)
      else $error("hex digit count overran");

endmodule

// ===== src/jsfe_rsp_fifo.sv =====
// Result queue: takes up to two result beats a cycle, issues one unless rsp is stalled.
module jsfe_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  jsfe_pkg::push_type push,
   output logic               room,
   output jsfe_pkg::rsp_type  head,
   output logic               rsp_valid,
   input  logic               rsp_stall
);
   import jsfe_pkg::*;

   localparam int PtrW = $clog2(RSP_DEPTH);
   localparam int CntW = PtrW + 1;

   rsp_type         mem_ff [RSP_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   // Leave space for a two-beat push regardless of a pop this cycle
   assign room      = (count_ff <= CntW'(RSP_DEPTH - 2));
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PtrW'(1)] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(RSP_DEPTH))
      else $error("result queue overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("push into a full queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && !pop) |=> $stable(count_ff))
      else $error("queue count moved while idle");

endmodule

// ===== src/json_string_field_extractor.sv =====
// Top level of the JSON string field extractor.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | in_byte, end_of_text
//  rsp     | out       | rsp_valid/rsp_stall  | out_byte, byte_valid, status, field_done
//  csr     | in/out    | psel/penable/pready  | key_bytes @0x0, key_length @0x8
//
// One text byte is accepted per cycle while the queue has room; its results enter
// a 4-entry result queue at the same edge, and the registered queue head is shown on rsp.
// A byte that yields two results (a decoded byte on the final byte of text)
// is issued as two result beats; the queue stalls req once it holds more than two.
// Reset is synchronous and clears the window, phase and queue; no clearing pass.
// A stall on rsp holds the head result; req keeps flowing until over two are queued.
module json_string_field_extractor #(
   parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_end_of_text,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_byte_valid,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_field_done,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [jsfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [jsfe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [jsfe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import jsfe_pkg::*;

   cfg_type  cfg;
   push_type push;
   rsp_type  head;
   logic     room;
   logic     accept;

   assign req_stall = !room;
   assign accept    = req_valid && !req_stall;

   jsfe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jsfe_step #(
      .KEY_MAX (KEY_MAX)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .cfg         (cfg),
      .push        (push)
   );

   jsfe_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .head      (head),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_byte_valid = head.byte_valid;
   assign rsp_status     = head.status;
   assign rsp_field_done = head.field_done;

endmodule
